// ----- rtl/srp_pkg.sv -----
// shared constants, types and saturating helpers for the ray to plane projection
`default_nettype none

package srp_pkg;

   localparam int COEF_BITS_DEF = 16;

   // quotient bits produced by each divider, one per pipeline stage
   localparam int QB = 32;

   // divider for the ray parameter: |num| * 2^16 and |den|
   localparam int TNW = 63;
   localparam int TDW = 64;

   // configuration register indexes
   localparam int CSR_IW = 3;
   localparam logic [CSR_IW-1:0] REG_CAM0  = 3'd0;
   localparam logic [CSR_IW-1:0] REG_CAM1  = 3'd1;
   localparam logic [CSR_IW-1:0] REG_CAM2  = 3'd2;
   localparam logic [CSR_IW-1:0] REG_CAM3  = 3'd3;
   localparam logic [CSR_IW-1:0] REG_PLANE = 3'd4;
   localparam logic [CSR_IW-1:0] REG_MAP0  = 3'd5;
   localparam logic [CSR_IW-1:0] REG_MAP1  = 3'd6;

   // result status codes
   localparam logic [1:0] ST_HIT    = 2'd0;
   localparam logic [1:0] ST_BEHIND = 2'd1;
   localparam logic [1:0] ST_DEGEN  = 2'd2;

   typedef logic signed [31:0] s32_type;
   typedef logic signed [63:0] s64_type;

   // 64-bit add that sticks at the extremes
   function automatic s64_type sadd64(input s64_type a, input s64_type b);
      logic signed [64:0] s;
      s = 65'(a) + 65'(b);
      if (s[64] != s[63]) begin
         return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      end
      return s[63:0];
   endfunction

   // saturate to 32 bits signed
   function automatic s32_type clamp32(input logic signed [65:0] v);
      if (v > 66'sd2147483647) begin
         return 32'sh7FFF_FFFF;
      end else if (v < -66'sd2147483648) begin
         return 32'sh8000_0000;
      end
      return v[31:0];
   endfunction

endpackage

`default_nettype wire

// ----- rtl/srp_div.sv -----
// pipelined restoring divider, one quotient bit per stage, lanes share the divisor
`default_nettype none

module srp_div import srp_pkg::*; #(
   parameter int L  = 1,
   parameter int NW = 64,
   parameter int DW = 64,
   parameter int SW = 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic                   in_valid,
   input  logic [L-1:0][NW-1:0]   in_num,
   input  logic [DW-1:0]          in_den,
   input  logic [SW-1:0]          in_side,
   output logic                   out_valid,
   output logic [L-1:0][QB-1:0]   out_quo,
   output logic [L-1:0]           out_ovf,
   output logic [SW-1:0]          out_side
);

   localparam int CW = NW + DW;

   logic [QB:0]              vld_ff;
   logic [DW-1:0]            den_ff  [QB];
   logic [SW-1:0]            side_ff [QB+1];
   logic [L-1:0][DW-1:0]     rem_ff  [QB];
   logic [L-1:0][QB-1:0]     low_ff  [QB];
   logic [L-1:0][QB-1:0]     quo_ff  [QB+1];
   logic [L-1:0]             ovf_ff  [QB+1];

   logic [L-1:0][DW-1:0]     rem_in  [QB];
   logic [L-1:0][QB-1:0]     low_in  [QB];
   logic [L-1:0][QB-1:0]     quo_in  [QB+1];
   logic [L-1:0]             ovf_in;

   // entry: quotient overflows 32 bits when the high part already reaches the divisor
   always_comb begin
      for (int l = 0; l < L; l++) begin
         ovf_in[l]    = CW'(in_num[l] >> QB) >= CW'(in_den);
         rem_in[0][l] = ovf_in[l] ? '0 : DW'(in_num[l] >> QB);
         low_in[0][l] = in_num[l][QB-1:0];
         quo_in[0][l] = '0;
      end
   end

   for (genvar k = 1; k <= QB; k++) begin : g_step
      logic [DW:0]  trial [L];
      logic [L-1:0] ge;
      always_comb begin
         for (int l = 0; l < L; l++) begin
            trial[l]     = {rem_ff[k-1][l], low_ff[k-1][l][QB-1]};
            ge[l]        = trial[l] >= {1'b0, den_ff[k-1]};
            quo_in[k][l] = {quo_ff[k-1][l][QB-2:0], ge[l]};
         end
      end
      if (k < QB) begin : g_rem
         always_comb begin
            for (int l = 0; l < L; l++) begin
               rem_in[k][l] = ge[l] ? DW'(trial[l] - {1'b0, den_ff[k-1]}) : DW'(trial[l]);
               low_in[k][l] = low_ff[k-1][l] << 1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[QB-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         den_ff[0]  <= in_den;
         side_ff[0] <= in_side;
         ovf_ff[0]  <= ovf_in;
         for (int s = 0; s <= QB; s++) begin
            quo_ff[s] <= quo_in[s];
         end
         for (int s = 0; s < QB; s++) begin
            rem_ff[s] <= rem_in[s];
            low_ff[s] <= low_in[s];
         end
         for (int s = 1; s < QB; s++) begin
            den_ff[s] <= den_ff[s-1];
         end
         for (int s = 1; s <= QB; s++) begin
            side_ff[s] <= side_ff[s-1];
            ovf_ff[s]  <= ovf_ff[s-1];
         end
      end
   end

   assign out_valid = vld_ff[QB];
   assign out_quo   = quo_ff[QB];
   assign out_ovf   = ovf_ff[QB];
   assign out_side  = side_ff[QB];

endmodule

`default_nettype wire

// ----- rtl/srp_cam.sv -----
// image point through the camera matrix: homogeneous world point h0..h3
`default_nettype none

module srp_cam import srp_pkg::*; #(
   parameter  int CB = COEF_BITS_DEF,
   localparam int HW = CB + 18
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  logic signed [15:0]   in_x,
   input  logic signed [15:0]   in_y,
   input  logic signed [CB-1:0] cam_c [4][4],
   output logic                 out_valid,
   output logic signed [HW-1:0] out_h [4]
);

   localparam int PW = CB + 16;

   logic                 v1_ff;
   logic                 v2_ff;
   logic signed [PW-1:0] px_ff [4];
   logic signed [PW-1:0] py_ff [4];
   logic signed [HW-1:0] h_ff  [4];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int r = 0; r < 4; r++) begin
            px_ff[r] <= PW'(cam_c[r][0]) * PW'(in_x);
            py_ff[r] <= PW'(cam_c[r][1]) * PW'(in_y);
            // z = -1 and w = 1 terms fold into (c3 - c2) scaled to Q.26
            h_ff[r]  <= HW'(px_ff[r]) + HW'(py_ff[r])
                      + ((HW'(cam_c[r][3]) - HW'(cam_c[r][2])) <<< 12);
         end
      end
   end

   assign out_valid = v2_ff;
   assign out_h     = h_ff;

endmodule

`default_nettype wire

// ----- rtl/srp_ray.sv -----
// ray direction, plane dot products and hit classification
`default_nettype none

module srp_ray import srp_pkg::*; #(
   parameter int CB = COEF_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  logic [2:0][QB-1:0]   in_quo,
   input  logic [2:0]           in_ovf,
   input  logic [2:0]           in_neg,
   input  logic                 in_zero_w,
   input  logic signed [CB-1:0] pos_c [3],
   input  logic signed [CB-1:0] nrm [3],
   input  logic signed [CB-1:0] ofs,
   output logic                 out_valid,
   output logic [TNW-1:0]       out_num,
   output logic [TDW-1:0]       out_den,
   output logic [1:0]           out_status,
   output s32_type              out_v [3]
);

   localparam int NV = CB + 32;
   localparam int NP = 2 * CB + 1;
   localparam s64_type NUM_HI = (64'sd1 <<< 46) - 64'sd1;
   localparam s64_type NUM_LO = -(64'sd1 <<< 46);

   logic [4:0]           vld_ff;
   logic [3:0]           zw_ff;
   s32_type              va_ff [3];
   s32_type              vb_ff [3];
   s32_type              vc_ff [3];
   s32_type              vd_ff [3];
   s32_type              ve_ff [3];
   logic signed [NV-1:0] nv_ff [3];
   logic signed [NP-1:0] np_ff [3];
   logic signed [NV-1:0] nv2_ff;
   s64_type              num_a_ff;
   s64_type              den_a_ff;
   s64_type              num_b_ff;
   s64_type              den_ff;
   logic [TNW-1:0]       num_out_ff;
   logic [TDW-1:0]       den_out_ff;
   logic [1:0]           st_ff;

   s32_type              pt    [3];
   logic signed [CB:0]   pos   [3];
   s32_type              v_in  [3];
   s64_type              num_c;
   s64_type              num_s;
   logic [1:0]           st_in;
   logic [46:0]          num_mag;

   // saturated point on the ray, then direction from the camera position
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         if (in_neg[r]) begin
            pt[r] = (in_ovf[r] || in_quo[r] > 32'h8000_0000) ? 32'sh8000_0000
                                                              : -signed'(in_quo[r]);
         end else begin
            pt[r] = (in_ovf[r] || in_quo[r][QB-1]) ? 32'sh7FFF_FFFF : signed'(in_quo[r]);
         end
         pos[r]  = -((CB+1)'(pos_c[r]));
         v_in[r] = clamp32(66'(pt[r]) - 66'(pos[r]));
      end
   end

   always_comb begin
      num_c = sadd64(num_b_ff, 64'(np_ff[2]));
      if (num_c > NUM_HI) begin
         num_s = NUM_HI;
      end else if (num_c < NUM_LO) begin
         num_s = NUM_LO;
      end else begin
         num_s = num_c;
      end
      if (zw_ff[3] || den_ff == 0) begin
         st_in = ST_DEGEN;
      end else if (num_s != 0 && ((num_s > 0) == (den_ff > 0))) begin
         st_in = ST_BEHIND;
      end else begin
         st_in = ST_HIT;
      end
      num_mag = num_s[63] ? 47'(-num_s) : 47'(num_s);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[3:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         zw_ff <= {zw_ff[2:0], in_zero_w};
         for (int r = 0; r < 3; r++) begin
            va_ff[r] <= v_in[r];
            vb_ff[r] <= va_ff[r];
            vc_ff[r] <= vb_ff[r];
            vd_ff[r] <= vc_ff[r];
            ve_ff[r] <= vd_ff[r];
            nv_ff[r] <= NV'(nrm[r]) * NV'(va_ff[r]);
            np_ff[r] <= NP'(nrm[r]) * NP'(pos[r]);
         end
         nv2_ff     <= nv_ff[2];
         num_a_ff   <= sadd64(64'(ofs) <<< 20, 64'(np_ff[0]));
         den_a_ff   <= sadd64(64'(nv_ff[0]), 64'(nv_ff[1]));
         num_b_ff   <= sadd64(num_a_ff, 64'(np_ff[1]));
         den_ff     <= sadd64(den_a_ff, 64'(nv2_ff));
         num_out_ff <= {num_mag, 16'd0};
         den_out_ff <= den_ff[63] ? 64'(-den_ff) : 64'(den_ff);
         st_ff      <= st_in;
      end
   end

   assign out_valid  = vld_ff[4];
   assign out_num    = num_out_ff;
   assign out_den    = den_out_ff;
   assign out_status = st_ff;
   assign out_v      = ve_ff;

endmodule

`default_nettype wire

// ----- rtl/srp_map.sv -----
// hit point along the ray and mapping into plane coordinates
`default_nettype none

module srp_map import srp_pkg::*; #(
   parameter int CB = COEF_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  logic [QB-1:0]        in_quo,
   input  logic                 in_ovf,
   input  logic [1:0]           in_status,
   input  s32_type              in_v [3],
   input  logic signed [CB-1:0] pos_c [3],
   input  logic signed [CB-1:0] map_c [2][4],
   output logic                 out_valid,
   output s32_type              out_x,
   output s32_type              out_y,
   output logic [1:0]           out_status
);

   localparam int MW = CB + 32;

   logic [6:0]           vld_ff;
   logic [1:0]           st_ff  [6];
   s64_type              tv_ff  [3];
   s32_type              hit_ff [3];
   logic signed [MW-1:0] mh_ff  [2][3];
   logic signed [MW-1:0] mh1_ff [2];
   logic signed [MW-1:0] mh2_ff [2];
   logic signed [MW-1:0] mh2b_ff [2];
   s64_type              acc_ff  [2];
   s64_type              acc2_ff [2];
   s64_type              acc3_ff [2];
   s32_type              x_ff;
   s32_type              y_ff;
   logic [1:0]           st_out_ff;

   s32_type              t;
   logic signed [CB:0]   pos  [3];
   logic signed [65:0]   s    [3];
   logic signed [65:0]   sadj [3];
   s32_type              hit_in [3];
   logic signed [65:0]   aadj [2];
   s32_type              res  [2];

   // t is never negative on a hit, so only the upper clamp matters
   always_comb begin
      t = (in_ovf || in_quo[QB-1]) ? 32'sh7FFF_FFFF : signed'(in_quo);
      for (int r = 0; r < 3; r++) begin
         pos[r]    = -((CB+1)'(pos_c[r]));
         s[r]      = (66'(pos[r]) <<< 16) + 66'(tv_ff[r]);
         sadj[r]   = s[r] + ((s[r] < 0) ? 66'sd65535 : 66'sd0);
         hit_in[r] = clamp32(sadj[r] >>> 16);
      end
      for (int j = 0; j < 2; j++) begin
         aadj[j] = 66'(acc3_ff[j]) + ((acc3_ff[j] < 0) ? 66'sd1023 : 66'sd0);
         res[j]  = (st_ff[5] == ST_HIT) ? clamp32(aadj[j] >>> 10) : 32'sd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[5:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         st_ff[0] <= in_status;
         for (int s_i = 1; s_i < 6; s_i++) begin
            st_ff[s_i] <= st_ff[s_i-1];
         end
         for (int r = 0; r < 3; r++) begin
            tv_ff[r]  <= 64'(t) * 64'(in_v[r]);
            hit_ff[r] <= hit_in[r];
         end
         for (int j = 0; j < 2; j++) begin
            for (int r = 0; r < 3; r++) begin
               mh_ff[j][r] <= MW'(map_c[j][r]) * MW'(hit_ff[r]);
            end
            acc_ff[j]  <= sadd64(64'(map_c[j][3]) <<< 14, 64'(mh_ff[j][0]));
            mh1_ff[j]  <= mh_ff[j][1];
            mh2_ff[j]  <= mh_ff[j][2];
            acc2_ff[j] <= sadd64(acc_ff[j], 64'(mh1_ff[j]));
            mh2b_ff[j] <= mh2_ff[j];
            acc3_ff[j] <= sadd64(acc2_ff[j], 64'(mh2b_ff[j]));
         end
         x_ff      <= res[0];
         y_ff      <= res[1];
         st_out_ff <= st_ff[5];
      end
   end

   assign out_valid  = vld_ff[6];
   assign out_x      = x_ff;
   assign out_y      = y_ff;
   assign out_status = st_out_ff;

endmodule

`default_nettype wire

// ----- rtl/camera_ray_plane_projection.sv -----
// top level: camera ray to plane projection pipeline with its register file
`default_nettype none

// Takes one image-plane point per cycle and returns its 2D coordinates on a
// configured plane, or a status of behind-camera or degenerate (w = 0 or a ray
// parallel to the plane) with zero coordinates. A point passes in order through
// the camera transform, the divide by w, the ray and plane dot products, the
// ray parameter divide and the hit point and plane map. Both divides are
// restoring dividers that settle one quotient bit per stage, which sets the
// depth. The whole pipeline advances together; it holds only while a finished
// result waits on rsp_ready, so with rsp_ready high a new point is taken every
// cycle. The user must write registers through the csr port only when no point
// is in flight; the block does not enforce this. Index 7 is ignored.
module camera_ray_plane_projection import srp_pkg::*; #(
   parameter int COEF_BITS = COEF_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   // input points
   input  logic              req_valid,
   output logic              req_ready,
   input  logic signed [15:0] req_image_x,
   input  logic signed [15:0] req_image_y,
   // results
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic signed [31:0] rsp_plane_x,
   output logic signed [31:0] rsp_plane_y,
   output logic [1:0]        rsp_status,
   // configuration
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [CSR_IW-1:0] csr_index,
   input  logic [63:0]       csr_data
);

   localparam int HW  = COEF_BITS + 18;
   localparam int NW1 = HW + 14;

   // register file
   logic [63:0] cam_ff [4];
   logic [63:0] plane_ff;
   logic [63:0] map_ff [2];

   // coefficient lanes
   logic signed [COEF_BITS-1:0] cam_c [4][4];
   logic signed [COEF_BITS-1:0] pos_c [3];
   logic signed [COEF_BITS-1:0] nrm   [3];
   logic signed [COEF_BITS-1:0] ofs;
   logic signed [COEF_BITS-1:0] map_c [2][4];

   // pipeline wiring
   logic                  en;
   logic                  cam_valid;
   logic signed [HW-1:0]  cam_h [4];
   logic [2:0][NW1-1:0]   d1_num;
   logic [HW-1:0]         d1_den;
   logic [3:0]            d1_side_in;
   logic                  d1_valid;
   logic [2:0][QB-1:0]    d1_quo;
   logic [2:0]            d1_ovf;
   logic [3:0]            d1_side;
   logic                  ray_valid;
   logic [TNW-1:0]        ray_num;
   logic [TDW-1:0]        ray_den;
   logic [1:0]            ray_status;
   s32_type               ray_v [3];
   logic [0:0][TNW-1:0]   d2_num;
   logic [97:0]           d2_side_in;
   logic                  d2_valid;
   logic [0:0][QB-1:0]    d2_quo;
   logic [0:0]            d2_ovf;
   logic [97:0]           d2_side;
   s32_type               map_v [3];

   function automatic logic signed [COEF_BITS-1:0] lane(input logic [63:0] r, input int k);
      logic [127:0]          e;
      logic [COEF_BITS-1:0]  raw;
      e   = {64'd0, r};
      raw = e[k*COEF_BITS +: COEF_BITS];
      return signed'(raw);
   endfunction

   // every register transfer is taken at once
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < 4; r++) begin
            cam_ff[r] <= '0;
         end
         plane_ff  <= '0;
         map_ff[0] <= '0;
         map_ff[1] <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_CAM0:  cam_ff[0] <= csr_data;
            REG_CAM1:  cam_ff[1] <= csr_data;
            REG_CAM2:  cam_ff[2] <= csr_data;
            REG_CAM3:  cam_ff[3] <= csr_data;
            REG_PLANE: plane_ff  <= csr_data;
            REG_MAP0:  map_ff[0] <= csr_data;
            REG_MAP1:  map_ff[1] <= csr_data;
            default: ;
         endcase
      end
   end

   // unpack lanes; fields past bit 63 read as zero
   always_comb begin
      for (int r = 0; r < 4; r++) begin
         for (int k = 0; k < 4; k++) begin
            cam_c[r][k] = lane(cam_ff[r], k);
         end
      end
      for (int r = 0; r < 3; r++) begin
         pos_c[r] = cam_c[r][3];
         nrm[r]   = lane(plane_ff, r);
      end
      ofs = lane(plane_ff, 3);
      for (int j = 0; j < 2; j++) begin
         for (int k = 0; k < 4; k++) begin
            map_c[j][k] = lane(map_ff[j], k);
         end
      end
   end

   // all stages step together unless the result register is stalled
   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;

   srp_cam #(.CB(COEF_BITS)) u_cam (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_valid),
      .in_x     (req_image_x),
      .in_y     (req_image_y),
      .cam_c    (cam_c),
      .out_valid(cam_valid),
      .out_h    (cam_h)
   );

   // sign and magnitude split for the divide by w
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         d1_num[r]     = {(cam_h[r][HW-1] ? HW'(-cam_h[r]) : HW'(cam_h[r])), 14'd0};
         d1_side_in[r] = cam_h[r][HW-1] ^ cam_h[3][HW-1];
      end
      d1_den        = cam_h[3][HW-1] ? HW'(-cam_h[3]) : HW'(cam_h[3]);
      d1_side_in[3] = cam_h[3] == 0;
   end

   srp_div #(.L(3), .NW(NW1), .DW(HW), .SW(4)) u_div_w (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (cam_valid),
      .in_num   (d1_num),
      .in_den   (d1_den),
      .in_side  (d1_side_in),
      .out_valid(d1_valid),
      .out_quo  (d1_quo),
      .out_ovf  (d1_ovf),
      .out_side (d1_side)
   );

   srp_ray #(.CB(COEF_BITS)) u_ray (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (d1_valid),
      .in_quo    (d1_quo),
      .in_ovf    (d1_ovf),
      .in_neg    (d1_side[2:0]),
      .in_zero_w (d1_side[3]),
      .pos_c     (pos_c),
      .nrm       (nrm),
      .ofs       (ofs),
      .out_valid (ray_valid),
      .out_num   (ray_num),
      .out_den   (ray_den),
      .out_status(ray_status),
      .out_v     (ray_v)
   );

   // status and ray direction ride along with the t divide
   assign d2_num[0]  = ray_num;
   assign d2_side_in = {ray_status, ray_v[2], ray_v[1], ray_v[0]};

   srp_div #(.L(1), .NW(TNW), .DW(TDW), .SW(98)) u_div_t (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (ray_valid),
      .in_num   (d2_num),
      .in_den   (ray_den),
      .in_side  (d2_side_in),
      .out_valid(d2_valid),
      .out_quo  (d2_quo),
      .out_ovf  (d2_ovf),
      .out_side (d2_side)
   );

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         map_v[r] = signed'(d2_side[32*r +: 32]);
      end
   end

   srp_map #(.CB(COEF_BITS)) u_map (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (d2_valid),
      .in_quo    (d2_quo[0]),
      .in_ovf    (d2_ovf[0]),
      .in_status (d2_side[97:96]),
      .in_v      (map_v),
      .pos_c     (pos_c),
      .map_c     (map_c),
      .out_valid (rsp_valid),
      .out_x     (rsp_plane_x),
      .out_y     (rsp_plane_y),
      .out_status(rsp_status)
   );

   // a miss or degenerate ray never carries coordinates
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_HIT |-> rsp_plane_x == 0 && rsp_plane_y == 0)
      else $error("non-hit result with nonzero coordinates");

   // a held result must block new points
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("input taken while result stalled");

   // a zero denominator is always classified degenerate before the t divide
   a_den_class: assert property (@(posedge clock) disable iff (reset)
      ray_valid && ray_den == 0 |-> ray_status == ST_DEGEN)
      else $error("zero denominator passed as hit or behind");

endmodule

`default_nettype wire

// ----- bench/ray_plane_checker.sv -----
// checker for the ray to plane projection: watches transfers, predicts results, compares
`timescale 1ns / 100ps

module ray_plane_checker import srp_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic signed [15:0] req_image_x,
   input  logic signed [15:0] req_image_y,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic signed [31:0] rsp_plane_x,
   input  logic signed [31:0] rsp_plane_y,
   input  logic [1:0]         rsp_status,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic [CSR_IW-1:0]  csr_index,
   input  logic [63:0]        csr_data,
   output int                 error_count,
   output int                 pending_count
);

   typedef struct packed {
      logic signed [31:0] px;
      logic signed [31:0] py;
      logic [1:0]         st;
   } plane_hit_type;

   logic [63:0]   shadow_regs [7];
   plane_hit_type hit_queue [$];

   function automatic longint coef(input logic [63:0] r, input int k);
      return longint'($signed(r[k*16 +: 16]));
   endfunction

   function automatic longint sat32(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // all intermediate sums stay well inside 64 bits at 16-bit lanes
   function automatic plane_hit_type project_point(input longint x, input longint y);
      plane_hit_type res;
      longint h [4];
      longint pos [3];
      longint dir [3];
      longint nrm [3];
      longint hitp [3];
      longint num, den, t, acc;
      res = '0;
      for (int r = 0; r < 4; r++) begin
         h[r] = coef(shadow_regs[r], 0) * x + coef(shadow_regs[r], 1) * y
              - coef(shadow_regs[r], 2) * 4096 + coef(shadow_regs[r], 3) * 4096;
      end
      if (h[3] == 0) begin
         res.st = ST_DEGEN;
         return res;
      end
      for (int r = 0; r < 3; r++) begin
         pos[r] = -coef(shadow_regs[r], 3);
         dir[r] = sat32(sat32((h[r] * 16384) / h[3]) - pos[r]);
         nrm[r] = coef(shadow_regs[REG_PLANE], r);
      end
      num = coef(shadow_regs[REG_PLANE], 3) * 1048576;
      den = 0;
      for (int r = 0; r < 3; r++) begin
         num += nrm[r] * pos[r];
         den += nrm[r] * dir[r];
      end
      if (num > (64'sd1 <<< 46) - 1) num = (64'sd1 <<< 46) - 1;
      if (num < -(64'sd1 <<< 46)) num = -(64'sd1 <<< 46);
      if (den == 0) begin
         res.st = ST_DEGEN;
         return res;
      end
      if (num != 0 && ((num > 0) == (den > 0))) begin
         res.st = ST_BEHIND;
         return res;
      end
      t = sat32(-((num * 65536) / den));
      for (int r = 0; r < 3; r++) begin
         hitp[r] = sat32((pos[r] * 65536 + t * dir[r]) / 65536);
      end
      for (int j = 0; j < 2; j++) begin
         acc = coef(shadow_regs[REG_MAP0 + j], 3) * 16384;
         for (int r = 0; r < 3; r++) acc += coef(shadow_regs[REG_MAP0 + j], r) * hitp[r];
         if (j == 0) res.px = 32'(sat32(acc / 1024));
         else res.py = 32'(sat32(acc / 1024));
      end
      res.st = ST_HIT;
      return res;
   endfunction

   always @(posedge clock) begin
      plane_hit_type want;
      if (reset) begin
         for (int i = 0; i < 7; i++) shadow_regs[i] = '0;
         hit_queue.delete();
         error_count <= 0;
         pending_count <= 0;
      end else begin
         if (csr_valid && csr_ready && csr_index <= REG_MAP1) begin
            shadow_regs[csr_index] = csr_data;
         end
         if (req_valid && req_ready) begin
            hit_queue.push_back(project_point(longint'(req_image_x), longint'(req_image_y)));
         end
         if (rsp_valid && rsp_ready) begin
            if (hit_queue.size() == 0) begin
               $display("%0t: unexpected result x=%0d y=%0d status=%0d", $time,
                        rsp_plane_x, rsp_plane_y, rsp_status);
               error_count <= error_count + 1;
            end else begin
               want = hit_queue.pop_front();
               if (want.px !== rsp_plane_x || want.py !== rsp_plane_y
                   || want.st !== rsp_status) begin
                  $display("%0t: mismatch expected x=%0d y=%0d status=%0d,",
                           $time, want.px, want.py, want.st,
                           " actual x=%0d y=%0d status=%0d",
                           rsp_plane_x, rsp_plane_y, rsp_status);
                  error_count <= error_count + 1;
               end
            end
         end
         pending_count <= hit_queue.size();
      end
   end

endmodule

// ----- bench/camera_ray_plane_projection_tb.sv -----
// testbench top: stimulus, receiver stalls, watchdog and verdict for the projection block
`timescale 1ns / 100ps

module camera_ray_plane_projection_tb;
   import srp_pkg::*;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic signed [15:0] req_image_x = '0;
   logic signed [15:0] req_image_y = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [31:0] rsp_plane_x;
   logic signed [31:0] rsp_plane_y;
   logic [1:0]         rsp_status;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [CSR_IW-1:0]  csr_index = '0;
   logic [63:0]        csr_data = '0;
   int                 error_count;
   int                 pending_count;
   logic               hold_go = 1'b0;   // asks the receiver for one long hold-off
   logic               hold_done = 1'b0;
   int                 burst_left = 0;

   localparam int IDLE_LIMIT = 20000;

   always #1 clock = ~clock;

   camera_ray_plane_projection u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_image_x(req_image_x), .req_image_y(req_image_y),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_plane_x(rsp_plane_x), .rsp_plane_y(rsp_plane_y), .rsp_status(rsp_status),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   ray_plane_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_image_x(req_image_x), .req_image_y(req_image_y),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_plane_x(rsp_plane_x), .rsp_plane_y(rsp_plane_y), .rsp_status(rsp_status),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data),
      .error_count(error_count), .pending_count(pending_count)
   );

   // receiver: stall pattern changes mode at random
   int stall_mode = 0;
   int mode_left = 0;
   int hold_left = 0;
   always @(posedge clock) begin
      if (hold_go && !hold_done) begin
         hold_done <= 1'b1;
         hold_left = 400;   // long hold-off so the pipeline fills and blocks the input
      end
      if (mode_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         mode_left = $urandom_range(10, 80);
      end else begin
         mode_left--;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         case (stall_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= ($urandom_range(0, 1) == 1);
            2: rsp_ready <= ($urandom_range(0, 3) == 0);
            default: rsp_ready <= ($urandom_range(0, 7) != 0);
         endcase
      end
   end

   // watchdog: cycles with no transfer on any channel
   int idle_cycles = 0;
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)
          || reset) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("camera_ray_plane_projection_tb: done, errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic logic [63:0] pack_lanes(input int a, input int b, input int c, input int d);
      return {d[15:0], c[15:0], b[15:0], a[15:0]};
   endfunction

   // one point transfer; valid stays high into the next point of a burst
   task automatic send_point(input logic [15:0] x, input logic [15:0] y);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      req_valid <= 1'b1;
      req_image_x <= x;
      req_image_y <= y;
      do @(posedge clock); while (!req_ready);
      burst_left--;
   endtask

   // register writes only with the pipeline drained
   task automatic write_reg(input logic [CSR_IW-1:0] idx, input logic [63:0] val);
      req_valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic load_setup(input logic [63:0] c0, input logic [63:0] c1, input logic [63:0] c2,
                             input logic [63:0] c3, input logic [63:0] pl,
                             input logic [63:0] m0, input logic [63:0] m1);
      write_reg(REG_CAM0, c0);
      write_reg(REG_CAM1, c1);
      write_reg(REG_CAM2, c2);
      write_reg(REG_CAM3, c3);
      write_reg(REG_PLANE, pl);
      write_reg(REG_MAP0, m0);
      write_reg(REG_MAP1, m1);
   endtask

   // camera near identity with random translation, plane and map of moderate size
   task automatic load_plausible();
      int j;
      j = 3000;
      load_setup(pack_lanes(16384 + $urandom_range(0, 2*j) - j, $urandom_range(0, 2*j) - j,
                            $urandom_range(0, 2*j) - j, $urandom_range(0, 16000) - 8000),
                 pack_lanes($urandom_range(0, 2*j) - j, 16384 + $urandom_range(0, 2*j) - j,
                            $urandom_range(0, 2*j) - j, $urandom_range(0, 16000) - 8000),
                 pack_lanes($urandom_range(0, 2*j) - j, $urandom_range(0, 2*j) - j,
                            16384 + $urandom_range(0, 2*j) - j, $urandom_range(0, 16000) - 8000),
                 pack_lanes($urandom_range(0, 600) - 300, $urandom_range(0, 600) - 300,
                            $urandom_range(0, 600) - 300, 16384 + $urandom_range(0, 2*j) - j),
                 pack_lanes($urandom_range(0, 32767) - 16384, $urandom_range(0, 32767) - 16384,
                            $urandom_range(0, 32767) - 16384, $urandom_range(0, 4000) - 2000),
                 pack_lanes($urandom_range(0, 64) - 32, $urandom_range(0, 64) - 32,
                            $urandom_range(0, 64) - 32, $urandom_range(0, 2000) - 1000),
                 pack_lanes($urandom_range(0, 64) - 32, $urandom_range(0, 64) - 32,
                            $urandom_range(0, 64) - 32, $urandom_range(0, 2000) - 1000));
   endtask

   task automatic load_raw();
      load_setup({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                 {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                 {$urandom, $urandom});
   endtask

   logic [63:0] id0, id1, id2, id3, map0, map1;

   initial begin
      id0 = pack_lanes(16384, 0, 0, 0);
      id1 = pack_lanes(0, 16384, 0, 0);
      id2 = pack_lanes(0, 0, 16384, 0);
      id3 = pack_lanes(0, 0, 0, 16384);
      map0 = pack_lanes(16, 0, 0, 0);
      map1 = pack_lanes(0, 16, 0, 0);

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // registers at reset: w is zero for every point
      send_point(16'h8000, 16'h7FFF);
      send_point(16'h0000, 16'hFFFF);

      // identity camera, plane z = -2 in front, identity map
      load_setup(id0, id1, id2, id3, pack_lanes(0, 0, 16384, 512), map0, map1);
      send_point(16'h0000, 16'h0000);
      send_point(16'h7FFF, 16'h7FFF);
      send_point(16'h8000, 16'h8000);
      send_point(16'h7FFF, 16'h8000);
      send_point(16'h8000, 16'h7FFF);
      send_point(16'hFFFF, 16'h0001);
      send_point(16'h1000, 16'hF000);
      // plane on the far side: behind the camera
      write_reg(REG_PLANE, pack_lanes(0, 0, 16384, -512));
      send_point(16'h0000, 16'h0000);
      send_point(16'h1234, 16'hEDCB);
      // normal along x: ray with x = 0 runs parallel
      write_reg(REG_PLANE, pack_lanes(16384, 0, 0, 256));
      send_point(16'h0000, 16'h4000);
      send_point(16'h2000, 16'h4000);
      // plane through the camera: hit at t = 0
      write_reg(REG_PLANE, pack_lanes(0, 0, 16384, 0));
      send_point(16'h0800, 16'h0800);
      // extreme map and translation
      load_setup(pack_lanes(16384, 0, 0, 32767), pack_lanes(0, 16384, 0, -32768), id2, id3,
                 pack_lanes(0, 0, 16384, 32767), pack_lanes(32767, 32767, 32767, 32767),
                 pack_lanes(-32768, -32768, -32768, -32768));
      send_point(16'h7FFF, 16'h8000);
      send_point(16'h8000, 16'h7FFF);
      // index past the last register is ignored by the block
      write_reg(3'd7, {$urandom, $urandom});
      send_point(16'h0100, 16'h0100);

      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            2: load_raw();
            4: load_setup({64{1'b1}}, {64{1'b1}}, {64{1'b1}}, {64{1'b1}},
                          {64{1'b1}}, {64{1'b1}}, {64{1'b1}});
            5: load_setup({4{16'h7FFF}}, {4{16'h8000}}, {4{16'h7FFF}}, {4{16'h8000}},
                          {4{16'h7FFF}}, {4{16'h8000}}, {4{16'h7FFF}});
            6: load_raw();
            default: load_plausible();
         endcase
         if (ph == 1) hold_go <= 1'b1;
         for (int i = 0; i < 200; i++) begin
            if ($urandom_range(0, 3) == 0) begin
               send_point(16'($urandom_range(0, 4096) - 2048), 16'($urandom_range(0, 4096) - 2048));
            end else begin
               send_point(16'($urandom), 16'($urandom));
            end
         end
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (error_count == 0) begin
         $display("camera_ray_plane_projection_tb: done, clean");
      end else begin
         $display("camera_ray_plane_projection_tb: done, errors");
      end
      $finish;
   end

endmodule
